// ----- sv/asct_pkg.sv -----
// ----------------------------------------------------------------------------
// asct_pkg: shared types and constants for the access site census table
// Action codes, register indexes, table entry layout and default sizes.
// ----------------------------------------------------------------------------
package asct_pkg;

	localparam int TABLE_DEPTH_DEF  = 256;
	localparam int WINDOW_BYTES_DEF = 4096;
	localparam int OFS_W            = 12;
	localparam int PADDR_W          = 4;

	localparam logic [1:0] ACT_FAULT = 2'd0;
	localparam logic [1:0] ACT_STEP  = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic REG_ENABLE      = 1'b0;
	localparam logic REG_WINDOW_BASE = 1'b1;

	typedef struct packed {
		logic        enable;
		logic [63:0] window_base;
	} cfg_t;

	typedef struct packed {
		logic [63:0]      key;
		logic [63:0]      reads;
		logic [63:0]      writes;
		logic [OFS_W-1:0] low;
		logic [OFS_W-1:0] high;
	} entry_t;

endpackage

// ----- sv/asct_apb.sv -----
// ----------------------------------------------------------------------------
// asct_apb: configuration registers
// APB-style write/read of enable and window_base, one register per 8 bytes.
// ----------------------------------------------------------------------------
module asct_apb (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [asct_pkg::PADDR_W-1:0]   paddr,
	input  logic [63:0]                    pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready,
	output asct_pkg::cfg_t                 cfg
);

	asct_pkg::cfg_t cfg_q;
	logic           wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3])
				asct_pkg::REG_ENABLE: begin
					cfg_q.enable <= pwdata[0];
				end
				asct_pkg::REG_WINDOW_BASE: begin
					cfg_q.window_base <= pwdata;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			asct_pkg::REG_ENABLE:      prdata = {63'd0, cfg_q.enable};
			asct_pkg::REG_WINDOW_BASE: prdata = cfg_q.window_base;
			default:                   prdata = '0;
		endcase
	end

endmodule

// ----- sv/asct_ram.sv -----
// ----------------------------------------------------------------------------
// asct_ram: site table storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module asct_ram #(
	parameter int DEPTH = asct_pkg::TABLE_DEPTH_DEF,
	parameter int AW    = 8,
	parameter int W     = $bits(asct_pkg::entry_t)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ----- sv/access_site_census_table.sv -----
// ----------------------------------------------------------------------------
// access_site_census_table: watch-window access census
// Records in-window access faults per instruction address in a site table,
// consumes single-step beats and reads back stored entries.
//
//   channel  handshake              payload
//   req      req_valid/req_ready    action, instr_address, fault_address,
//                                   write_access, entry_index
//   rsp      rsp_valid/rsp_ready    handled .. entry_high_offset
//   apb      psel/penable/pready    paddr, pwdata, prdata
//
// Fault beat in window: one key compare per cycle over the filled entries
// through the table read port, then an update of the matching entry, a new
// entry, or a drop when the table is full. Out-of-window, step, disabled and
// spare beats leave the table alone; a read beat reads the table only for a
// filled entry. req_ready is high only while the sequencer idles.
// A finished result waits in the rsp register; the next beat may be taken
// meanwhile. Reset clears fill, counters and the stepping flag; table
// contents stay undefined and only filled entries are ever read.
// ----------------------------------------------------------------------------
module access_site_census_table #(
	parameter int TABLE_DEPTH  = asct_pkg::TABLE_DEPTH_DEF,
	parameter int WINDOW_BYTES = asct_pkg::WINDOW_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [asct_pkg::PADDR_W-1:0]  paddr,
	input  logic [63:0]                   pwdata,
	output logic [63:0]                   prdata,
	output logic                          pready,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [1:0]                    action,
	input  logic [63:0]                   instr_address,
	input  logic [63:0]                   fault_address,
	input  logic                          write_access,
	input  logic [7:0]                    entry_index,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          handled,
	output logic                          new_site,
	output logic                          site_dropped,
	output logic [7:0]                    site_slot,
	output logic [8:0]                    sites_in_use,
	output logic [63:0]                   hit_total,
	output logic [63:0]                   drop_total,
	output logic [63:0]                   entry_key,
	output logic [63:0]                   entry_read_count,
	output logic [63:0]                   entry_write_count,
	output logic [asct_pkg::OFS_W-1:0]    entry_low_offset,
	output logic [asct_pkg::OFS_W-1:0]    entry_high_offset
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OFS_W = asct_pkg::OFS_W;
	localparam int ENT_W = $bits(asct_pkg::entry_t);

	typedef enum logic [2:0] {
		S_IDLE, S_CHK, S_SCAN, S_MISS, S_RD, S_RDW, S_FIN
	} state_t;

	typedef struct packed {
		logic                handled;
		logic                new_site;
		logic                dropped;
		logic [7:0]          slot;
		asct_pkg::entry_t    ent;
	} res_t;

	asct_pkg::cfg_t   cfg;
	state_t           state_q;
	logic [63:0]      key_q;
	logic [63:0]      faddr_q;
	logic             wr_q;
	logic [7:0]       eidx_q;
	logic [OFS_W-1:0] ofs_q;
	logic [CNT_W-1:0] fill_q;
	logic [63:0]      hit_q;
	logic [63:0]      drop_q;
	logic             step_q;
	logic [CNT_W-1:0] scan_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	res_t             res_q;
	res_t             out_q;
	logic             out_vld_q;
	logic [8:0]       out_fill_q;
	logic [63:0]      out_hit_q;
	logic [63:0]      out_drop_q;

	logic             we;
	logic [IDX_W-1:0] waddr;
	asct_pkg::entry_t wdata;
	logic             re;
	logic [IDX_W-1:0] raddr;
	logic [ENT_W-1:0] rdata;
	asct_pkg::entry_t rd_ent;
	asct_pkg::entry_t upd;
	asct_pkg::entry_t nw;
	logic             match;
	logic             issue;
	logic             fill_room;
	logic             rd_ok;
	logic [63:0]      ofs64;
	logic             in_win;
	logic [31:0]      cmp_idx32;
	logic [31:0]      fill32;
	logic [31:0]      eidx32;
	logic             out_load;

	asct_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	asct_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IDX_W),
		.W     (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_ent    = asct_pkg::entry_t'(rdata);
	assign match     = cmp_vld_s1 && (rd_ent.key == key_q);
	assign fill_room = fill_q < CNT_W'(TABLE_DEPTH);
	assign issue     = (state_q == S_SCAN) && !match && (scan_q < fill_q);
	assign cmp_idx32 = 32'(cmp_idx_s1);
	assign fill32    = 32'(fill_q);
	assign eidx32    = 32'(eidx_q);
	assign rd_ok     = eidx32 < fill32;
	assign ofs64     = faddr_q - cfg.window_base;
	assign in_win    = ofs64 < 64'(WINDOW_BYTES);
	assign req_ready = (state_q == S_IDLE);
	assign out_load  = (state_q == S_FIN) && (!out_vld_q || rsp_ready);

	always_comb begin
		upd = rd_ent;
		if (wr_q) begin
			upd.writes = rd_ent.writes + 64'd1;
		end else begin
			upd.reads = rd_ent.reads + 64'd1;
		end
		if (ofs_q < rd_ent.low) begin
			upd.low = ofs_q;
		end
		if (ofs_q > rd_ent.high) begin
			upd.high = ofs_q;
		end
	end

	always_comb begin
		nw.key    = key_q;
		nw.reads  = {63'd0, !wr_q};
		nw.writes = {63'd0, wr_q};
		nw.low    = ofs_q;
		nw.high   = ofs_q;
	end

	always_comb begin
		we    = 1'b0;
		waddr = cmp_idx_s1;
		wdata = upd;
		re    = 1'b0;
		raddr = scan_q[IDX_W-1:0];
		unique case (state_q)
			S_SCAN: begin
				we = match;
				re = issue;
			end
			S_MISS: begin
				we    = fill_room;
				waddr = fill_q[IDX_W-1:0];
				wdata = nw;
			end
			S_RD: begin
				re    = rd_ok;
				raddr = eidx32[IDX_W-1:0];
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			key_q      <= '0;
			faddr_q    <= '0;
			wr_q       <= 1'b0;
			eidx_q     <= '0;
			ofs_q      <= '0;
			fill_q     <= '0;
			hit_q      <= '0;
			drop_q     <= '0;
			step_q     <= 1'b0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			res_q      <= '0;
			out_q      <= '0;
			out_vld_q  <= 1'b0;
			out_fill_q <= '0;
			out_hit_q  <= '0;
			out_drop_q <= '0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						key_q          <= instr_address;
						faddr_q        <= fault_address;
						wr_q           <= write_access;
						eidx_q         <= entry_index;
						res_q.handled  <= cfg.enable && (action == asct_pkg::ACT_STEP)
							&& step_q;
						res_q.new_site <= 1'b0;
						res_q.dropped  <= 1'b0;
						res_q.slot     <= '0;
						res_q.ent      <= '0;
						if (cfg.enable) begin
							unique case (action)
								asct_pkg::ACT_FAULT: state_q <= S_CHK;
								asct_pkg::ACT_STEP: begin
									step_q  <= 1'b0;
									state_q <= S_FIN;
								end
								asct_pkg::ACT_READ: state_q <= S_RD;
								default: state_q <= S_FIN;
							endcase
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_CHK: begin
					scan_q     <= '0;
					cmp_vld_s1 <= 1'b0;
					ofs_q      <= ofs64[OFS_W-1:0];
					if (in_win) begin
						hit_q         <= hit_q + 64'd1;
						step_q        <= 1'b1;
						res_q.handled <= 1'b1;
						state_q       <= S_SCAN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (match) begin
						res_q.slot <= cmp_idx32[7:0];
						cmp_vld_s1 <= 1'b0;
						state_q    <= S_FIN;
					end else begin
						cmp_vld_s1 <= issue;
						cmp_idx_s1 <= scan_q[IDX_W-1:0];
						if (issue) begin
							scan_q <= scan_q + CNT_W'(1);
						end else begin
							state_q <= S_MISS;
						end
					end
				end
				S_MISS: begin
					if (fill_room) begin
						fill_q         <= fill_q + CNT_W'(1);
						res_q.new_site <= 1'b1;
						res_q.slot     <= fill32[7:0];
					end else begin
						drop_q        <= drop_q + 64'd1;
						res_q.dropped <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_RD: begin
					state_q <= rd_ok ? S_RDW : S_FIN;
				end
				S_RDW: begin
					res_q.handled <= 1'b1;
					res_q.ent     <= rd_ent;
					state_q       <= S_FIN;
				end
				S_FIN: begin
					if (out_load) begin
						out_q      <= res_q;
						out_fill_q <= fill32[8:0];
						out_hit_q  <= hit_q;
						out_drop_q <= drop_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid         = out_vld_q;
	assign handled           = out_q.handled;
	assign new_site          = out_q.new_site;
	assign site_dropped      = out_q.dropped;
	assign site_slot         = out_q.slot;
	assign sites_in_use      = out_fill_q;
	assign hit_total         = out_hit_q;
	assign drop_total        = out_drop_q;
	assign entry_key         = out_q.ent.key;
	assign entry_read_count  = out_q.ent.reads;
	assign entry_write_count = out_q.ent.writes;
	assign entry_low_offset  = out_q.ent.low;
	assign entry_high_offset = out_q.ent.high;

`ifndef SYNTHESIS
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(drop_q != $past(drop_q)) |-> (fill_q == CNT_W'(TABLE_DEPTH)))
		else $error("site dropped while table has room");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(we && state_q == S_MISS) |=> (fill_q == CNT_W'($past(fill_q) + CNT_W'(1))))
		else $error("new entry written without fill advance");

	a_hit_step: assert property (@(posedge clk) disable iff (!arst_n)
		(hit_q != $past(hit_q)) |-> step_q)
		else $error("recorded hit without stepping flag");

	a_new_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(new_site && site_dropped))
		else $error("result both new and dropped");
`endif

endmodule

// ----- tb/sv/asct_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asct_tb_pkg: beat types and census scoreboard for the site table bench
// Holds a cycle-free predictor of the census table (own copy of the table,
// counters, stepping flag and registers) and the queue of predicted results.
// ----------------------------------------------------------------------------
package asct_tb_pkg;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] instr_address;
		logic [63:0] fault_address;
		logic        write_access;
		logic [7:0]  entry_index;
	} census_req_t;

	typedef struct packed {
		logic                       handled;
		logic                       new_site;
		logic                       site_dropped;
		logic [7:0]                 site_slot;
		logic [8:0]                 sites_in_use;
		logic [63:0]                hit_total;
		logic [63:0]                drop_total;
		logic [63:0]                entry_key;
		logic [63:0]                entry_read_count;
		logic [63:0]                entry_write_count;
		logic [asct_pkg::OFS_W-1:0] entry_low_offset;
		logic [asct_pkg::OFS_W-1:0] entry_high_offset;
	} census_rsp_t;

	class census_scoreboard;
		bit                         enable;
		bit [63:0]                  window_base;
		bit [63:0]                  key_at    [asct_pkg::TABLE_DEPTH_DEF];
		bit [63:0]                  reads_at  [asct_pkg::TABLE_DEPTH_DEF];
		bit [63:0]                  writes_at [asct_pkg::TABLE_DEPTH_DEF];
		bit [asct_pkg::OFS_W-1:0]   low_at    [asct_pkg::TABLE_DEPTH_DEF];
		bit [asct_pkg::OFS_W-1:0]   high_at   [asct_pkg::TABLE_DEPTH_DEF];
		int unsigned                fill;
		bit [63:0]                  hit_count;
		bit [63:0]                  drop_count;
		bit                         stepping;
		census_rsp_t                due_results[$];
		int unsigned                errors;

		function void set_register(logic idx, logic [63:0] value);
			if (idx == asct_pkg::REG_ENABLE) begin
				enable = value[0];
			end else begin
				window_base = value;
			end
		endfunction

		function int unsigned outstanding();
			return due_results.size();
		endfunction

		// Predict the result of one accepted request beat and queue it.
		function void note_request(census_req_t r);
			census_rsp_t              o;
			logic [63:0]              ofs;
			bit [asct_pkg::OFS_W-1:0] ofs_lo;
			int                       slot;
			int                       i;
			o = '0;
			if (enable) begin
				unique case (r.action)
					asct_pkg::ACT_FAULT: begin
						ofs = r.fault_address - window_base;
						ofs_lo = ofs[asct_pkg::OFS_W-1:0];
						if (ofs < 64'(asct_pkg::WINDOW_BYTES_DEF)) begin
							o.handled = 1'b1;
							hit_count++;
							stepping = 1'b1;
							slot = -1;
							for (i = 0; i < int'(fill) && slot < 0; i++)
								if (key_at[i] == r.instr_address) slot = i;
							if (slot >= 0) begin
								if (r.write_access) writes_at[slot]++;
								else reads_at[slot]++;
								if (ofs_lo < low_at[slot]) low_at[slot] = ofs_lo;
								if (ofs_lo > high_at[slot]) high_at[slot] = ofs_lo;
								o.site_slot = slot[7:0];
							end else if (fill >= asct_pkg::TABLE_DEPTH_DEF) begin
								drop_count++;
								o.site_dropped = 1'b1;
							end else begin
								key_at[fill]    = r.instr_address;
								low_at[fill]    = ofs_lo;
								high_at[fill]   = ofs_lo;
								reads_at[fill]  = r.write_access ? 64'd0 : 64'd1;
								writes_at[fill] = r.write_access ? 64'd1 : 64'd0;
								o.new_site  = 1'b1;
								o.site_slot = fill[7:0];
								fill++;
							end
						end
					end
					asct_pkg::ACT_STEP: begin
						if (stepping) begin
							stepping = 1'b0;
							o.handled = 1'b1;
						end
					end
					asct_pkg::ACT_READ: begin
						if (r.entry_index < fill) begin
							o.handled           = 1'b1;
							o.entry_key         = key_at[r.entry_index];
							o.entry_read_count  = reads_at[r.entry_index];
							o.entry_write_count = writes_at[r.entry_index];
							o.entry_low_offset  = low_at[r.entry_index];
							o.entry_high_offset = high_at[r.entry_index];
						end
					end
					default: ;
				endcase
			end
			o.sites_in_use = fill[8:0];
			o.hit_total    = hit_count;
			o.drop_total   = drop_count;
			due_results.push_back(o);
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task cmp(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want) report($sformatf("%s got %h expected %h", field, got, want));
		endtask

		task check_response(census_rsp_t got);
			census_rsp_t want;
			if (due_results.size() == 0) begin
				report("result beat with nothing predicted");
				return;
			end
			want = due_results.pop_front();
			cmp("handled", 64'(got.handled), 64'(want.handled));
			cmp("new_site", 64'(got.new_site), 64'(want.new_site));
			cmp("site_dropped", 64'(got.site_dropped), 64'(want.site_dropped));
			cmp("site_slot", 64'(got.site_slot), 64'(want.site_slot));
			cmp("sites_in_use", 64'(got.sites_in_use), 64'(want.sites_in_use));
			cmp("hit_total", got.hit_total, want.hit_total);
			cmp("drop_total", got.drop_total, want.drop_total);
			cmp("entry_key", got.entry_key, want.entry_key);
			cmp("entry_read_count", got.entry_read_count, want.entry_read_count);
			cmp("entry_write_count", got.entry_write_count, want.entry_write_count);
			cmp("entry_low_offset", 64'(got.entry_low_offset),
				64'(want.entry_low_offset));
			cmp("entry_high_offset", 64'(got.entry_high_offset),
				64'(want.entry_high_offset));
		endtask
	endclass

endpackage

// ----- tb/sv/tb_access_site_census_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_access_site_census_table: self-checking bench for the site census table
// Directed beats cover window edges, key extremes, steps and entry reads,
// then phases of random beats under several register settings fill the
// table to overflow. Both channels idle at random; every result is checked
// field by field against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_access_site_census_table;

	localparam logic [1:0] ACT_SPARE = 2'd3;
	localparam int         PADDR_W   = asct_pkg::PADDR_W;
	localparam int         OFS_W     = asct_pkg::OFS_W;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [63:0]         pwdata;
	logic [63:0]         prdata;
	logic                pready;
	logic                req_valid;
	logic                req_ready;
	logic [1:0]          action;
	logic [63:0]         instr_address;
	logic [63:0]         fault_address;
	logic                write_access;
	logic [7:0]          entry_index;
	logic                rsp_valid;
	logic                rsp_ready;
	logic                handled;
	logic                new_site;
	logic                site_dropped;
	logic [7:0]          site_slot;
	logic [8:0]          sites_in_use;
	logic [63:0]         hit_total;
	logic [63:0]         drop_total;
	logic [63:0]         entry_key;
	logic [63:0]         entry_read_count;
	logic [63:0]         entry_write_count;
	logic [OFS_W-1:0]    entry_low_offset;
	logic [OFS_W-1:0]    entry_high_offset;

	asct_tb_pkg::census_scoreboard tracker = new();
	bit                            snd_calm;
	bit                            rcv_calm;
	logic [63:0]                   cur_base;
	logic [63:0]                   key_pool[$];

	access_site_census_table DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.req_valid         (req_valid),
		.req_ready         (req_ready),
		.action            (action),
		.instr_address     (instr_address),
		.fault_address     (fault_address),
		.write_access      (write_access),
		.entry_index       (entry_index),
		.rsp_valid         (rsp_valid),
		.rsp_ready         (rsp_ready),
		.handled           (handled),
		.new_site          (new_site),
		.site_dropped      (site_dropped),
		.site_slot         (site_slot),
		.sites_in_use      (sites_in_use),
		.hit_total         (hit_total),
		.drop_total        (drop_total),
		.entry_key         (entry_key),
		.entry_read_count  (entry_read_count),
		.entry_write_count (entry_write_count),
		.entry_low_offset  (entry_low_offset),
		.entry_high_offset (entry_high_offset)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("FAIL access_site_census_table");
		$finish;
	end

	function automatic asct_tb_pkg::census_req_t make_req(logic [1:0] act,
			logic [63:0] key, logic [63:0] addr, logic wr, logic [7:0] idx);
		asct_tb_pkg::census_req_t r;
		r.action        = act;
		r.instr_address = key;
		r.fault_address = addr;
		r.write_access  = wr;
		r.entry_index   = idx;
		return r;
	endfunction

	task automatic send_req(input asct_tb_pkg::census_req_t r);
		int unsigned gap;
		if ($urandom_range(0, 31) == 0) snd_calm = !snd_calm;
		gap = snd_calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid     <= 1'b1;
		action        <= r.action;
		instr_address <= r.instr_address;
		fault_address <= r.fault_address;
		write_access  <= r.write_access;
		entry_index   <= r.entry_index;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(r);
	endtask

	// park the request side until every predicted result has come back
	task automatic settle();
		req_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_register(idx, value);
	endtask

	task automatic random_item(input int unsigned fresh_pct);
		asct_tb_pkg::census_req_t r;
		int unsigned pick;
		int unsigned sel;
		bit          fresh;
		r.action        = ACT_SPARE;
		r.instr_address = {$urandom, $urandom};
		r.fault_address = {$urandom, $urandom};
		r.write_access  = 1'($urandom_range(0, 1));
		r.entry_index   = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 99);
		if (pick < 55) begin
			r.action = asct_pkg::ACT_FAULT;
			fresh = (key_pool.size() == 0) || ($urandom_range(0, 99) < fresh_pct);
			if (fresh) begin
				key_pool.push_back(r.instr_address);
			end else begin
				r.instr_address = key_pool[$urandom_range(0, key_pool.size() - 1)];
				if ($urandom_range(0, 19) == 0)
					r.instr_address[$urandom_range(0, 63)] ^= 1'b1;
			end
			sel = $urandom_range(0, 99);
			if (sel < 8) r.fault_address = cur_base;
			else if (sel < 16) r.fault_address = cur_base + 64'd4095;
			else if (sel < 85) r.fault_address = cur_base + 64'($urandom_range(0, 4095));
			else if (sel < 90) r.fault_address = cur_base + 64'd4096 +
				64'($urandom_range(0, 4095));
			else if (sel < 95) r.fault_address = cur_base - 64'd1 -
				64'($urandom_range(0, 4095));
		end else if (pick < 70) begin
			r.action = asct_pkg::ACT_STEP;
		end else if (pick < 93) begin
			r.action = asct_pkg::ACT_READ;
			if (tracker.fill != 0 && $urandom_range(0, 9) < 8)
				r.entry_index = 8'($urandom_range(0, tracker.fill - 1));
		end
		send_req(r);
		if ($urandom_range(0, 149) == 0) settle();
	endtask

	initial begin : rsp_side
		asct_tb_pkg::census_rsp_t got;
		int unsigned              stall;
		rsp_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0) rcv_calm = !rcv_calm;
			stall = rcv_calm ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
			got.handled           = handled;
			got.new_site          = new_site;
			got.site_dropped      = site_dropped;
			got.site_slot         = site_slot;
			got.sites_in_use      = sites_in_use;
			got.hit_total         = hit_total;
			got.drop_total        = drop_total;
			got.entry_key         = entry_key;
			got.entry_read_count  = entry_read_count;
			got.entry_write_count = entry_write_count;
			got.entry_low_offset  = entry_low_offset;
			got.entry_high_offset = entry_high_offset;
			tracker.check_response(got);
		end
	end

	initial begin : stimulus
		logic [63:0] b;
		logic [63:0] ones;
		logic        en;
		int unsigned count;
		int unsigned fresh_pct;
		int          phase;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		req_valid     <= 1'b0;
		action        <= asct_pkg::ACT_FAULT;
		instr_address <= '0;
		fault_address <= '0;
		write_access  <= 1'b0;
		entry_index   <= '0;
		ones = '1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled out of reset: in-window fault is ignored
		send_req(make_req(asct_pkg::ACT_FAULT, 64'd1, 64'd0, 1'b0, 8'd0));
		settle();
		b = 64'h1000;
		cur_base = b;
		write_reg(asct_pkg::REG_ENABLE, 64'd1);
		write_reg(asct_pkg::REG_WINDOW_BASE, b);
		send_req(make_req(asct_pkg::ACT_STEP, ones, ones, 1'b1, 8'hFF));
		send_req(make_req(asct_pkg::ACT_READ, 64'd0, 64'd0, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, 64'd0, b, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_STEP, 64'd0, 64'd0, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_STEP, 64'd0, 64'd0, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, 64'd0, b + 64'd4095, 1'b1, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, ones, b + 64'd2048, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, ones, b + 64'd4096, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, ones, b - 64'd1, 1'b1, 8'd0));
		send_req(make_req(asct_pkg::ACT_STEP, 64'd0, 64'd0, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, 64'd0, b + 64'd100, 1'b1, 8'd0));
		send_req(make_req(asct_pkg::ACT_READ, 64'd0, 64'd0, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_READ, 64'd0, 64'd0, 1'b0, 8'd1));
		send_req(make_req(asct_pkg::ACT_READ, 64'd0, 64'd0, 1'b0, 8'd2));
		send_req(make_req(asct_pkg::ACT_READ, ones, ones, 1'b1, 8'd255));
		send_req(make_req(ACT_SPARE, ones, b, 1'b1, 8'hFF));
		send_req(make_req(asct_pkg::ACT_FAULT, 64'h8000_0000_0000_0000, b + 64'd1,
			1'b1, 8'd0));
		send_req(make_req(asct_pkg::ACT_FAULT, 64'h7FFF_FFFF_FFFF_FFFF, b + 64'd4094,
			1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_STEP, 64'd0, 64'd0, 1'b0, 8'd0));
		send_req(make_req(asct_pkg::ACT_READ, 64'd0, 64'd0, 1'b0, 8'd2));
		send_req(make_req(asct_pkg::ACT_READ, 64'd0, 64'd0, 1'b0, 8'd3));

		for (phase = 0; phase < 6; phase++) begin
			en = 1'b1;
			fresh_pct = 55;
			count = 240;
			unique case (phase)
				0: b = 64'd0;
				1: b = 64'hFFFF_FFFF_FFFF_F800;  // window wraps through zero
				2: begin
					en = 1'b0;
					b = {$urandom, $urandom};
					count = 80;
				end
				3: b = ones;
				4: begin
					b = {$urandom, $urandom};
					fresh_pct = 65;
					count = 300;
				end
				default: begin
					b = 64'h0000_0000_8000_0000;
					fresh_pct = 50;
					count = 260;
				end
			endcase
			settle();
			write_reg(asct_pkg::REG_ENABLE, {63'd0, en});
			write_reg(asct_pkg::REG_WINDOW_BASE, b);
			cur_base = b;
			repeat (count) random_item(fresh_pct);
		end

		settle();
		repeat (300) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0) begin
			$display("PASS access_site_census_table");
		end else begin
			$display("FAIL access_site_census_table");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/asct_pkg.sv
sv/asct_apb.sv
sv/asct_ram.sv
sv/access_site_census_table.sv
tb/sv/asct_tb_pkg.sv
tb/sv/tb_access_site_census_table.sv
